// File: src/connection_id_translation_table_macros.svh
// assertion macros for the connection id translation table
`ifndef CONNECTION_ID_TRANSLATION_TABLE_MACROS_SVH
`define CONNECTION_ID_TRANSLATION_TABLE_MACROS_SVH
`define CITT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CITT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// File: src/citt_pkg.sv
// package with types and constants for the connection id translation table
package citt_pkg;
    localparam int unsigned DefTableEntries = 64;
    localparam int unsigned DefSocketBits   = 16;
    localparam int unsigned QueueDepth      = 2;

    typedef enum logic [2:0] {
        CMD_GET_OR_CREATE = 3'd0,
        CMD_REVERSE       = 3'd1,
        CMD_LIST          = 3'd2,
        CMD_DEL_PAIR      = 3'd3,
        CMD_DEL_SOCKET    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] socket_handle;
        logic [31:0] client_id;
        logic [31:0] server_id_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] server_id_out;
        logic [15:0] socket_out;
        logic [31:0] client_id_out;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        known;
        logic [2:0]  command;
        logic [15:0] socket;
        logic [31:0] client_id;
        logic [31:0] server_id;
    } t_job;
endpackage

// File: src/connection_id_translation_table.sv
// top level of the connection id translation table
//  channel | direction | handshake         | payload
//  in      | input     | i_valid/o_stall   | t_in_item
//  out     | output    | o_valid/i_stall   | t_out_item
// a known command walks every slot, each slot a registered ram read (S_READ), then a compare
// (S_CHECK); then S_EMIT, S_WRITE when a new entry is written, and S_DONE, which registers
// the result; jobs wait in the input queue first, and unknown commands skip the walk to S_DONE
// reset clears slot valid flags and the id counter
// a stalled output holds the back end in S_DONE, and a list walk stalls at a slot while a
// result is pending and the output still held; the input queue takes items until it holds two
module connection_id_translation_table #(
    parameter int unsigned TABLE_ENTRIES = citt_pkg::DefTableEntries,
    parameter int unsigned SOCKET_BITS   = citt_pkg::DefSocketBits
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  citt_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output citt_pkg::t_out_item o_item
);
    import citt_pkg::*;

    logic w_job_valid, w_job_take;
    t_job w_job;

    citt_front #(.SOCKET_BITS(SOCKET_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_job_valid(w_job_valid), .i_job_take(w_job_take), .o_job(w_job));

    citt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_job_valid), .o_job_take(w_job_take),
        .i_job(w_job), .o_valid, .i_stall, .o_item);
endmodule

// File: src/citt_ram.sv
// generic single port ram with registered read
module citt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/citt_front.sv
// front end: accepts transactions, classifies and queues them
module citt_front #(
    parameter int unsigned SOCKET_BITS = citt_pkg::DefSocketBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  citt_pkg::t_in_item i_item,
    output logic               o_job_valid,
    input  logic               i_job_take,
    output citt_pkg::t_job     o_job
);
    import citt_pkg::*;
    localparam int unsigned PtrBits = $clog2(QueueDepth);
    localparam logic [15:0] SockMask = 16'((33'd1 << SOCKET_BITS) - 33'd1);

    t_job               r_q [QueueDepth];
    logic [PtrBits-1:0] r_wp, r_rp;
    logic [PtrBits:0]   r_cnt;
    t_job               n_job;
    logic               w_push, w_pop;

    always_comb begin
        n_job.known     = (i_item.command <= CMD_DEL_SOCKET);
        n_job.command   = i_item.command;
        n_job.socket    = i_item.socket_handle & SockMask;
        n_job.client_id = i_item.client_id;
        n_job.server_id = i_item.server_id_in;
    end

    assign o_stall     = (r_cnt == (PtrBits+1)'(QueueDepth));
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != '0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrBits+1)'(w_push) - (PtrBits+1)'(w_pop);
        end
    end
endmodule

// File: src/citt_back.sv
// back end: walks the table slot by slot for known commands and produces results
`include "connection_id_translation_table_macros.svh"
module citt_back #(
    parameter int unsigned TABLE_ENTRIES = citt_pkg::DefTableEntries
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_take,
    input  citt_pkg::t_job      i_job,
    output logic                o_valid,
    input  logic                i_stall,
    output citt_pkg::t_out_item o_item
);
    import citt_pkg::*;
    localparam int unsigned AB = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CHECK = 6'b000100,
        S_WRITE = 6'b001000,
        S_EMIT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                   r_state;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [AB-1:0]            r_idx, n_idx;
    logic [31:0]              r_ctr;
    t_job                     r_job;
    logic                     r_hit, r_free_found, r_any;
    logic [AB-1:0]            r_free;
    logic                     r_pend;
    t_out_item                r_pend_item;
    logic                     r_ovalid;
    t_out_item                r_oitem;

    logic          w_we;
    logic [AB-1:0] w_addr;
    logic [15:0]   w_sock;
    logic [31:0]   w_cli, w_srv;
    logic          w_slot_v, w_sock_eq, w_pair_eq, w_last_slot, w_out_free;
    logic          w_list_out, w_done_out;

    citt_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_sock (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(r_job.socket), .o_rdata(w_sock));
    citt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_cli (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(r_job.client_id), .o_rdata(w_cli));
    citt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_srv (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(r_ctr + 32'd1), .o_rdata(w_srv));

    assign w_we        = (r_state == S_WRITE);
    assign w_addr      = (r_state == S_WRITE) ? r_free : r_idx;
    assign w_slot_v    = r_valid[r_idx];
    assign w_sock_eq   = w_slot_v && (w_sock == r_job.socket);
    assign w_pair_eq   = w_sock_eq && (w_cli == r_job.client_id);
    assign w_last_slot = (r_idx == AB'(TABLE_ENTRIES-1));
    assign w_out_free  = !r_ovalid || !i_stall;
    assign w_list_out  = (r_state == S_CHECK) && (r_job.command == CMD_LIST)
                         && r_pend && w_out_free && w_sock_eq;
    assign w_done_out  = (r_state == S_DONE) && w_out_free;
    assign o_job_take  = (r_state == S_IDLE) && i_job_valid;
    assign o_valid     = r_ovalid;
    assign o_item      = r_oitem;

    function automatic t_out_item mk(logic [1:0] st, logic [31:0] sid,
                                     logic [15:0] sk, logic [31:0] cid, logic lst);
        t_out_item o;
        o.status = st; o.server_id_out = sid; o.socket_out = sk;
        o.client_id_out = cid; o.last = lst;
        return o;
    endfunction

    always_comb begin
        n_idx = r_idx;
        if (r_state == S_CHECK) n_idx = r_idx + 1'b1;
        if (r_state == S_IDLE)  n_idx = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ctr    <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_ovalid <= w_list_out || w_done_out || (r_ovalid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_job_valid) begin
                        r_job        <= i_job;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_any        <= 1'b0;
                        r_pend       <= !i_job.known;
                        if (!i_job.known) begin
                            r_pend_item <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                            r_state     <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_job.command == CMD_LIST && r_pend && !w_out_free) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= w_last_slot ? S_EMIT : S_READ;
                        r_idx   <= n_idx;
                        unique case (r_job.command)
                            CMD_GET_OR_CREATE: begin
                                if (w_pair_eq && !r_hit) begin
                                    r_hit       <= 1'b1;
                                    r_pend_item <= mk(ST_OK, w_srv, '0, '0, 1'b1);
                                end
                                if (!w_slot_v && !r_free_found) begin
                                    r_free_found <= 1'b1;
                                    r_free       <= r_idx;
                                end
                            end
                            CMD_REVERSE: begin
                                if (w_slot_v && w_srv == r_job.server_id && !r_hit) begin
                                    r_hit       <= 1'b1;
                                    r_pend_item <= mk(ST_OK, w_srv, w_sock, w_cli, 1'b1);
                                end
                            end
                            CMD_LIST: begin
                                if (w_sock_eq) begin
                                    if (r_pend) begin
                                        r_oitem <= r_pend_item;
                                    end
                                    r_pend      <= 1'b1;
                                    r_any       <= 1'b1;
                                    r_pend_item <= mk(ST_OK, w_srv, '0, '0, 1'b0);
                                end
                            end
                            CMD_DEL_PAIR: begin
                                if (w_pair_eq && !r_hit) begin
                                    r_hit          <= 1'b1;
                                    r_valid[r_idx] <= 1'b0;
                                end
                            end
                            default: begin
                                if (w_sock_eq) begin
                                    r_hit          <= 1'b1;
                                    r_valid[r_idx] <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    r_pend  <= 1'b1;
                    r_state <= (r_job.command == CMD_GET_OR_CREATE && !r_hit && r_free_found)
                               ? S_WRITE : S_DONE;
                    unique case (r_job.command)
                        CMD_GET_OR_CREATE: begin
                            if (!r_hit) begin
                                if (r_free_found) begin
                                    r_pend_item <= mk(ST_OK, r_ctr + 32'd1, '0, '0, 1'b1);
                                end else begin
                                    r_pend_item <= mk(ST_FULL, '0, '0, '0, 1'b1);
                                end
                            end
                        end
                        CMD_REVERSE:
                            if (!r_hit) r_pend_item <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                        CMD_LIST: begin
                            if (r_any) r_pend_item.last <= 1'b1;
                            else r_pend_item <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                        end
                        default: r_pend_item <= mk(r_hit ? ST_OK : ST_NOTFOUND,
                                                   '0, '0, '0, 1'b1);
                    endcase
                end
                S_WRITE: begin
                    r_valid[r_free] <= 1'b1;
                    r_ctr           <= r_ctr + 32'd1;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_oitem  <= r_pend_item;
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CITT_ASSERT(a_take_idle, i_clk, i_rst_n, o_job_take |-> r_state == S_IDLE, "take outside idle")
    `CITT_ASSERT(a_last_done, i_clk, i_rst_n, (r_state == S_DONE && w_out_free) |=> o_valid && o_item.last, "final result missing last")
    `CITT_ASSERT(a_write_ctr, i_clk, i_rst_n, (r_state == S_WRITE) |=> r_ctr == $past(r_ctr) + 32'd1, "counter not advanced on create")
    `CITT_ASSERT_NEVER(a_full_write, i_clk, i_rst_n, r_state == S_WRITE && !r_free_found, "write with no free slot")
endmodule

// File: sim/testbench.sv
// testbench for the connection id translation table: directed and random command streams
`timescale 1ns / 1ps

module testbench;
    import citt_pkg::*;

    localparam int Slots = 64;
    localparam int IdleLimit = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    connection_id_translation_table DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    // predicted table contents
    logic        tbl_used [Slots];
    logic [15:0] tbl_sock [Slots];
    logic [31:0] tbl_cid  [Slots];
    logic [31:0] tbl_sid  [Slots];
    logic [31:0] next_id;

    t_out_item pending_results [$];
    int        mismatches;
    int        send_idle_pct;
    int        stall_pct;
    int        quiet_cycles;
    logic      timed_out;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item make_result(t_status st, logic [31:0] sid,
                                              logic [15:0] sk, logic [31:0] cid,
                                              logic lst);
        t_out_item r;
        r.status = st;
        r.server_id_out = sid;
        r.socket_out = sk;
        r.client_id_out = cid;
        r.last = lst;
        return r;
    endfunction

    task automatic queue_result(input t_out_item r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic predict_table(input t_in_item it);
        int hit;
        int n;
        hit = -1;
        n = 0;
        case (it.command)
            CMD_GET_OR_CREATE, CMD_DEL_PAIR: begin
                for (int i = 0; i < Slots; i++)
                    if (hit < 0 && tbl_used[i] && tbl_sock[i] == it.socket_handle
                        && tbl_cid[i] == it.client_id) hit = i;
                if (it.command == CMD_DEL_PAIR) begin
                    if (hit >= 0) tbl_used[hit] = 1'b0;
                    queue_result(make_result(hit >= 0 ? ST_OK : ST_NOTFOUND,
                                             '0, '0, '0, 1'b1));
                end else if (hit >= 0) begin
                    queue_result(make_result(ST_OK, tbl_sid[hit], '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < Slots; i++)
                        if (hit < 0 && !tbl_used[i]) hit = i;
                    if (hit < 0) begin
                        queue_result(make_result(ST_FULL, '0, '0, '0, 1'b1));
                    end else begin
                        next_id = next_id + 32'd1;
                        tbl_used[hit] = 1'b1;
                        tbl_sock[hit] = it.socket_handle;
                        tbl_cid[hit] = it.client_id;
                        tbl_sid[hit] = next_id;
                        queue_result(make_result(ST_OK, next_id, '0, '0, 1'b1));
                    end
                end
            end
            CMD_REVERSE: begin
                for (int i = 0; i < Slots; i++)
                    if (hit < 0 && tbl_used[i] && tbl_sid[i] == it.server_id_in) hit = i;
                if (hit >= 0)
                    queue_result(make_result(ST_OK, it.server_id_in,
                                             tbl_sock[hit], tbl_cid[hit], 1'b1));
                else
                    queue_result(make_result(ST_NOTFOUND, '0, '0, '0, 1'b1));
            end
            CMD_LIST: begin
                for (int i = 0; i < Slots; i++)
                    if (tbl_used[i] && tbl_sock[i] == it.socket_handle) begin
                        queue_result(make_result(ST_OK, tbl_sid[i], '0, '0, 1'b0));
                        n++;
                    end
                if (n == 0)
                    queue_result(make_result(ST_NOTFOUND, '0, '0, '0, 1'b1));
                else
                    pending_results[$].last = 1'b1;
            end
            CMD_DEL_SOCKET: begin
                for (int i = 0; i < Slots; i++)
                    if (tbl_used[i] && tbl_sock[i] == it.socket_handle) begin
                        tbl_used[i] = 1'b0;
                        n++;
                    end
                queue_result(make_result(n > 0 ? ST_OK : ST_NOTFOUND, '0, '0, '0, 1'b1));
            end
            default: queue_result(make_result(ST_NOTFOUND, '0, '0, '0, 1'b1));
        endcase
    endtask

    task automatic send_command(input logic [2:0] cmd, input logic [15:0] sk,
                                input logic [31:0] cid, input logic [31:0] sid);
        t_in_item it;
        it.command = cmd;
        it.socket_handle = sk;
        it.client_id = cid;
        it.server_id_in = sid;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_table(it);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %p", o_item);
                end else if (o_item !== pending_results[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", pending_results[0], o_item);
                    void'(pending_results.pop_front());
                end else begin
                    void'(pending_results.pop_front());
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IdleLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("connection_id_translation_table test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_socket();
        return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(7));
    endfunction

    task automatic test_directed();
        send_command(CMD_REVERSE, 16'h0, '0, 32'h0);
        send_command(CMD_LIST, 16'hffff, '0, '0);
        send_command(CMD_DEL_PAIR, 16'h0, '0, '0);
        send_command(CMD_DEL_SOCKET, 16'h0, '0, '0);
        send_command(CMD_GET_OR_CREATE, 16'h0, 32'h0, '0);
        send_command(CMD_GET_OR_CREATE, 16'hffff, 32'hffffffff, '0);
        send_command(CMD_GET_OR_CREATE, 16'hffff, 32'h0, '0);
        send_command(CMD_GET_OR_CREATE, 16'h0, 32'h0, '0);
        send_command(CMD_REVERSE, '0, '0, 32'd2);
        send_command(CMD_REVERSE, '0, '0, 32'hffffffff);
        send_command(CMD_LIST, 16'hffff, '0, '0);
        send_command(CMD_DEL_PAIR, 16'hffff, 32'hffffffff, '0);
        send_command(CMD_LIST, 16'hffff, '0, '0);
        send_command(CMD_DEL_SOCKET, 16'hffff, '0, '0);
        for (logic [3:0] c = 5; c <= 7; c++)
            send_command(c[2:0], 16'hffff, 32'hffffffff, 32'hffffffff);
        send_command(CMD_DEL_SOCKET, 16'h0, '0, '0);
    endtask

    // fill the table, hit the full case, then list a socket with all slots
    task automatic test_table_full();
        for (int i = 0; i < Slots + 2; i++)
            send_command(CMD_GET_OR_CREATE, 16'h00a5, 32'(i), '0);
        send_command(CMD_LIST, 16'h00a5, '0, '0);
        send_command(CMD_DEL_PAIR, 16'h00a5, 32'd5, '0);
        send_command(CMD_GET_OR_CREATE, 16'h1234, 32'hdeadbeef, '0);
        send_command(CMD_REVERSE, '0, '0, next_id);
        send_command(CMD_DEL_SOCKET, 16'h00a5, '0, '0);
        send_command(CMD_DEL_SOCKET, 16'h1234, '0, '0);
    endtask

    task automatic test_random(input int count);
        int r;
        logic [2:0] cmd;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            cmd = r < 40 ? CMD_GET_OR_CREATE : r < 60 ? CMD_REVERSE : r < 75 ? CMD_LIST
                : r < 88 ? CMD_DEL_PAIR : r < 97 ? CMD_DEL_SOCKET : 3'($urandom_range(5, 7));
            send_command(cmd, pick_socket(),
                         $urandom_range(1) ? 32'($urandom_range(5)) : $urandom,
                         $urandom_range(3) != 0 ? 32'($urandom_range(next_id + 2)) : $urandom);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;
        mismatches = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        next_id = 0;
        for (int i = 0; i < Slots; i++) tbl_used[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_random(105);
        send_idle_pct = 68;
        test_random(105);
        send_idle_pct = 0;
        stall_pct = 68;
        test_random(105);
        send_idle_pct = 34;
        stall_pct = 34;
        test_random(105);
        stall_pct = 0;
        send_idle_pct = 0;
        wait_drained();

        if (mismatches == 0)
            $display("connection_id_translation_table test passed");
        else
            $display("connection_id_translation_table test failed");
        $finish;
    end
endmodule
